// ----- rtl/core/bcsc_pkg.sv -----
// ----------------------------------------------------------------------------
// bcsc_pkg
// Shared types, opcodes and sizes of the bytecode register-stack cpu step.
// ----------------------------------------------------------------------------
package bcsc_pkg;

  localparam int STACK_WORDS = 64;
  localparam int SLOT_W      = $clog2(STACK_WORDS);
  localparam int REG_COUNT   = 8;
  localparam int REG_W       = $clog2(REG_COUNT);

  localparam logic [REG_W-1:0] SP_IDX = REG_W'(4);

  localparam logic [7:0] OP_HALT   = 8'h00;
  localparam logic [7:0] OP_MOV_I  = 8'h01;
  localparam logic [7:0] OP_MOV_R  = 8'h02;
  localparam logic [7:0] OP_ADD_I  = 8'h03;
  localparam logic [7:0] OP_ADD_R  = 8'h04;
  localparam logic [7:0] OP_SUB_I  = 8'h05;
  localparam logic [7:0] OP_SUB_R  = 8'h06;
  localparam logic [7:0] OP_PUSH_I = 8'h07;
  localparam logic [7:0] OP_PUSH_R = 8'h08;
  localparam logic [7:0] OP_POP    = 8'h09;
  localparam logic [7:0] OP_JMP_I  = 8'h0A;
  localparam logic [7:0] OP_JMP_R  = 8'h0B;
  localparam logic [7:0] OP_CALL_I = 8'h0C;
  localparam logic [7:0] OP_CALL_R = 8'h0D;
  localparam logic [7:0] OP_RET    = 8'h0E;
  localparam logic [7:0] OP_RETN   = 8'h0F;
  localparam logic [7:0] OP_AND_I  = 8'h10;
  localparam logic [7:0] OP_AND_R  = 8'h11;
  localparam logic [7:0] OP_OR_I   = 8'h12;
  localparam logic [7:0] OP_OR_R   = 8'h13;
  localparam logic [7:0] OP_XOR_I  = 8'h14;
  localparam logic [7:0] OP_XOR_R  = 8'h15;

  typedef logic [31:0]       word_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [REG_W-1:0]  reg_idx_t;

  typedef struct packed {
    word_t    pc;
    logic     halt;
    logic     wb_en;
    reg_idx_t wb_addr;
    word_t    wb_data;
    word_t    sp;
    logic     st_en;
    slot_t    st_addr;
    word_t    st_data;
  } exec_res_t;

  function automatic slot_t slot_of(word_t sp_val);
    return sp_val[SLOT_W+1:2];
  endfunction

endpackage

// ----- rtl/core/bcsc_ram.sv -----
// ----------------------------------------------------------------------------
// bcsc_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module bcsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/bcsc_exec.sv -----
// ----------------------------------------------------------------------------
// bcsc_exec
// Executes one decoded instruction against the current architectural state.
// ----------------------------------------------------------------------------
module bcsc_exec import bcsc_pkg::*; (
  input  logic [7:0] op,
  input  reg_idx_t   ra,
  input  word_t      imm,
  input  logic [7:0] drop,
  input  word_t      va,
  input  word_t      vb,
  input  word_t      top,
  input  word_t      pc,
  input  word_t      sp,
  input  logic       halt,
  output exec_res_t  res
);

  word_t alu;
  word_t sp_inc;
  word_t drop_bytes;

  assign sp_inc     = sp + 32'd4;
  assign drop_bytes = {22'd0, drop, 2'b00} + 32'd4;

  always_comb begin
    case (op)
      OP_MOV_I: alu = imm;
      OP_MOV_R: alu = vb;
      OP_ADD_I: alu = va + imm;
      OP_ADD_R: alu = va + vb;
      OP_SUB_I: alu = va - imm;
      OP_SUB_R: alu = va - vb;
      OP_AND_I: alu = va & imm;
      OP_AND_R: alu = va & vb;
      OP_OR_I:  alu = va | imm;
      OP_OR_R:  alu = va | vb;
      OP_XOR_I: alu = va ^ imm;
      OP_XOR_R: alu = va ^ vb;
      default:  alu = va;
    endcase
  end

  always_comb begin
    res.pc      = pc;
    res.halt    = halt;
    res.wb_en   = 1'b0;
    res.wb_addr = ra;
    res.wb_data = alu;
    res.sp      = sp;
    res.st_en   = 1'b0;
    res.st_addr = slot_of(sp_inc);
    res.st_data = imm;
    if (!halt) begin
      unique case (op) inside
        OP_HALT: begin
          res.halt = 1'b1;
          res.pc   = pc + 32'd1;
        end
        OP_MOV_I, OP_ADD_I, OP_SUB_I, OP_AND_I, OP_OR_I, OP_XOR_I: begin
          res.wb_en = 1'b1;
          res.sp    = (ra == SP_IDX) ? alu : sp;
          res.pc    = pc + 32'd6;
        end
        OP_MOV_R, OP_ADD_R, OP_SUB_R, OP_AND_R, OP_OR_R, OP_XOR_R: begin
          res.wb_en = 1'b1;
          res.sp    = (ra == SP_IDX) ? alu : sp;
          res.pc    = pc + 32'd3;
        end
        OP_PUSH_I: begin
          res.sp    = sp_inc;
          res.st_en = 1'b1;
          res.pc    = pc + 32'd5;
        end
        OP_PUSH_R: begin
          res.sp      = sp_inc;
          res.st_en   = 1'b1;
          res.st_data = (ra == SP_IDX) ? sp_inc : va;
          res.pc      = pc + 32'd2;
        end
        OP_POP: begin
          res.wb_en   = 1'b1;
          res.wb_data = top;
          res.sp      = ((ra == SP_IDX) ? top : sp) - 32'd4;
          res.pc      = pc + 32'd2;
        end
        OP_JMP_I: res.pc = imm;
        OP_JMP_R: res.pc = va;
        OP_CALL_I: begin
          res.sp      = sp_inc;
          res.st_en   = 1'b1;
          res.st_data = pc + 32'd5;
          res.pc      = imm;
        end
        OP_CALL_R: begin
          res.sp      = sp_inc;
          res.st_en   = 1'b1;
          res.st_data = pc + 32'd2;
          res.pc      = (ra == SP_IDX) ? sp_inc : va;
        end
        OP_RET: begin
          res.pc = top;
          res.sp = sp - 32'd4;
        end
        OP_RETN: begin
          res.pc = top;
          res.sp = sp - drop_bytes;
        end
        default: res.pc = pc + 32'd1;
      endcase
    end
  end

endmodule

// ----- rtl/core/bytecode_register_stack_cpu_step.sv -----
// ----------------------------------------------------------------------------
// bytecode_register_stack_cpu_step
// An accepted instruction waits in the input register until it executes, and
// its result is registered on the outputs. Throughput: one instruction per
// cycle; register file and stack reads are issued at the accept edge with
// write-to-read forwarding, so only output back-pressure stalls the input.
// Reset clears pc, all registers, the halt flag and both handshakes;
// stack memory contents are not cleared.
// ----------------------------------------------------------------------------
module bytecode_register_stack_cpu_step import bcsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] operation,
  input  logic [2:0] first_register,
  input  logic [2:0] second_register,
  input  word_t      immediate,
  input  logic [7:0] drop_count,
  output logic       out_valid,
  input  logic       out_ready,
  output word_t      next_pc,
  output logic       halted,
  output word_t      accumulator_value,
  output word_t      counter_value
);

  logic       in_valid_q;
  logic [7:0] op_q;
  reg_idx_t   ra_q;
  reg_idx_t   rb_q;
  word_t      imm_q;
  logic [7:0] drop_q;

  word_t pc;
  word_t sp;
  word_t r0;
  word_t r1;
  logic  halt;
  logic [REG_COUNT-1:0] rf_valid;

  logic  rf_fwd_a;
  logic  rf_fwd_b;
  word_t rf_fwd_data;
  logic  st_fwd;
  word_t st_fwd_data;

  logic      in_fire;
  logic      exec_fire;
  reg_idx_t  rf_raddr_a;
  reg_idx_t  rf_raddr_b;
  word_t     rf_rdata_a;
  word_t     rf_rdata_b;
  logic      rf_we;
  word_t     va;
  word_t     vb;
  word_t     sp_next;
  slot_t     st_raddr;
  word_t     st_rdata;
  logic      st_we;
  word_t     top;
  word_t     r0_next;
  word_t     r1_next;
  exec_res_t res;

  assign exec_fire = in_valid_q && (!out_valid || out_ready);
  assign in_ready  = !in_valid_q || exec_fire;
  assign in_fire   = in_valid && in_ready;

  assign rf_raddr_a = in_fire ? first_register  : ra_q;
  assign rf_raddr_b = in_fire ? second_register : rb_q;
  assign rf_we      = exec_fire && res.wb_en;

  bcsc_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (res.wb_addr),
    .wdata (res.wb_data),
    .raddr (rf_raddr_a),
    .rdata (rf_rdata_a)
  );

  bcsc_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (res.wb_addr),
    .wdata (res.wb_data),
    .raddr (rf_raddr_b),
    .rdata (rf_rdata_b)
  );

  // stack pointer lives in its own register; unwritten entries read as zero
  always_comb begin
    if (ra_q == SP_IDX) begin
      va = sp;
    end else if (rf_fwd_a) begin
      va = rf_fwd_data;
    end else if (rf_valid[ra_q]) begin
      va = rf_rdata_a;
    end else begin
      va = '0;
    end
    if (rb_q == SP_IDX) begin
      vb = sp;
    end else if (rf_fwd_b) begin
      vb = rf_fwd_data;
    end else if (rf_valid[rb_q]) begin
      vb = rf_rdata_b;
    end else begin
      vb = '0;
    end
  end

  assign sp_next  = exec_fire ? res.sp : sp;
  assign st_raddr = slot_of(sp_next);
  assign st_we    = exec_fire && res.st_en;
  assign top      = st_fwd ? st_fwd_data : st_rdata;

  bcsc_ram #(.WIDTH(32), .DEPTH(STACK_WORDS)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (res.st_addr),
    .wdata (res.st_data),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  bcsc_exec u_exec (
    .op   (op_q),
    .ra   (ra_q),
    .imm  (imm_q),
    .drop (drop_q),
    .va   (va),
    .vb   (vb),
    .top  (top),
    .pc   (pc),
    .sp   (sp),
    .halt (halt),
    .res  (res)
  );

  assign r0_next = (rf_we && res.wb_addr == REG_W'(0)) ? res.wb_data : r0;
  assign r1_next = (rf_we && res.wb_addr == REG_W'(1)) ? res.wb_data : r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
      out_valid  <= 1'b0;
      pc         <= '0;
      sp         <= '0;
      r0         <= '0;
      r1         <= '0;
      halt       <= 1'b0;
      rf_valid   <= '0;
      rf_fwd_a   <= 1'b0;
      rf_fwd_b   <= 1'b0;
      st_fwd     <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (exec_fire) begin
        in_valid_q <= 1'b0;
      end
      if (exec_fire) begin
        out_valid <= 1'b1;
        pc        <= res.pc;
        halt      <= res.halt;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      sp <= sp_next;
      r0 <= r0_next;
      r1 <= r1_next;
      if (rf_we) begin
        rf_valid[res.wb_addr] <= 1'b1;
      end
      rf_fwd_a <= rf_we && (res.wb_addr == rf_raddr_a);
      rf_fwd_b <= rf_we && (res.wb_addr == rf_raddr_b);
      st_fwd   <= st_we && (res.st_addr == st_raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q   <= operation;
      ra_q   <= first_register;
      rb_q   <= second_register;
      imm_q  <= immediate;
      drop_q <= drop_count;
    end
    rf_fwd_data <= res.wb_data;
    st_fwd_data <= res.st_data;
    if (exec_fire) begin
      next_pc           <= res.pc;
      halted            <= res.halt;
      accumulator_value <= r0_next;
      counter_value     <= r1_next;
    end
  end

endmodule

// ----- rtl/core/bcsc_checker.sv -----
// ----------------------------------------------------------------------------
// bcsc_checker
// Port-level checks of the cpu step, bound to the top level.
// ----------------------------------------------------------------------------
module bcsc_checker import bcsc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input word_t      next_pc,
  input logic       halted,
  input word_t      accumulator_value,
  input word_t      counter_value
);

  logic       in_fire;
  logic       out_fire;
  logic [1:0] pending;
  logic       seen_halt;
  word_t      halt_pc;
  word_t      halt_acc;
  word_t      halt_cnt;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      seen_halt <= 1'b0;
    end else begin
      pending <= pending + 2'(in_fire) - 2'(out_fire);
      if (out_fire && halted) begin
        seen_halt <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      halt_pc  <= next_pc;
      halt_acc <= accumulator_value;
      halt_cnt <= counter_value;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(halted))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0 && pending <= 2'd2)
    else $error("result without a pending transaction");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_halt |-> halted && next_pc == halt_pc &&
      accumulator_value == halt_acc && counter_value == halt_cnt)
    else $error("state changed after halt");

endmodule

bind bytecode_register_stack_cpu_step bcsc_checker u_bcsc_checker (.*);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Runs bytecode instructions through bytecode_register_stack_cpu_step and
// compares every result with an in-bench instruction-set model: directed alu,
// stack and control-flow cases, random programs built from call/return frames
// and push/pop pairs plus noise, output back-pressure, a drain pause, and halt.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bcsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned MAX_REPORTS    = 30;

  typedef struct packed {
    logic [7:0] op;
    reg_idx_t   ra;
    reg_idx_t   rb;
    word_t      imm;
    logic [7:0] drop;
  } instr_t;

  typedef struct packed {
    word_t pc;
    logic  halt;
    word_t acc;
    word_t cnt;
  } cpu_view_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] operation;
  logic [2:0] first_register;
  logic [2:0] second_register;
  word_t      immediate;
  logic [7:0] drop_count;
  logic       out_valid;
  logic       out_ready;
  word_t      next_pc;
  logic       halted;
  word_t      accumulator_value;
  word_t      counter_value;

  word_t model_pc;
  word_t model_regs [REG_COUNT];
  word_t model_stack [STACK_WORDS];
  bit    model_written [STACK_WORDS];
  logic  model_halt;

  cpu_view_t   pending_states[$];
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  bit          idle_on      = 1'b1;
  bit          hold_req     = 1'b0;

  bytecode_register_stack_cpu_step u_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .operation         (operation),
    .first_register    (first_register),
    .second_register   (second_register),
    .immediate         (immediate),
    .drop_count        (drop_count),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .next_pc           (next_pc),
    .halted            (halted),
    .accumulator_value (accumulator_value),
    .counter_value     (counter_value)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic int unsigned stack_slot(word_t sp_val);
    return (sp_val >> 2) % STACK_WORDS;
  endfunction

  function automatic void stack_write(word_t value);
    int unsigned slot;
    slot = stack_slot(model_regs[SP_IDX]);
    model_stack[slot]   = value;
    model_written[slot] = 1'b1;
  endfunction

  function automatic word_t stack_top();
    return model_stack[stack_slot(model_regs[SP_IDX])];
  endfunction

  function automatic void model_reset();
    model_pc   = '0;
    model_halt = 1'b0;
    foreach (model_regs[i]) model_regs[i] = '0;
    foreach (model_written[i]) model_written[i] = 1'b0;
  endfunction

  function automatic cpu_view_t run_instruction(instr_t it);
    word_t     pc;
    cpu_view_t view;
    pc = model_pc;
    if (!model_halt) begin
      case (it.op)
        OP_HALT: begin
          model_halt = 1'b1;
          pc = pc + 32'd1;
        end
        OP_MOV_I: begin model_regs[it.ra] = it.imm; pc = pc + 32'd6; end
        OP_MOV_R: begin model_regs[it.ra] = model_regs[it.rb]; pc = pc + 32'd3; end
        OP_ADD_I: begin model_regs[it.ra] += it.imm; pc = pc + 32'd6; end
        OP_ADD_R: begin model_regs[it.ra] += model_regs[it.rb]; pc = pc + 32'd3; end
        OP_SUB_I: begin model_regs[it.ra] -= it.imm; pc = pc + 32'd6; end
        OP_SUB_R: begin model_regs[it.ra] -= model_regs[it.rb]; pc = pc + 32'd3; end
        OP_AND_I: begin model_regs[it.ra] &= it.imm; pc = pc + 32'd6; end
        OP_AND_R: begin model_regs[it.ra] &= model_regs[it.rb]; pc = pc + 32'd3; end
        OP_OR_I:  begin model_regs[it.ra] |= it.imm; pc = pc + 32'd6; end
        OP_OR_R:  begin model_regs[it.ra] |= model_regs[it.rb]; pc = pc + 32'd3; end
        OP_XOR_I: begin model_regs[it.ra] ^= it.imm; pc = pc + 32'd6; end
        OP_XOR_R: begin model_regs[it.ra] ^= model_regs[it.rb]; pc = pc + 32'd3; end
        OP_PUSH_I: begin
          model_regs[SP_IDX] += 32'd4;
          stack_write(it.imm);
          pc = pc + 32'd5;
        end
        // register is read after the pointer moved
        OP_PUSH_R: begin
          model_regs[SP_IDX] += 32'd4;
          stack_write(model_regs[it.ra]);
          pc = pc + 32'd2;
        end
        OP_POP: begin
          model_regs[it.ra] = stack_top();
          model_regs[SP_IDX] -= 32'd4;
          pc = pc + 32'd2;
        end
        OP_JMP_I: pc = it.imm;
        OP_JMP_R: pc = model_regs[it.ra];
        OP_CALL_I: begin
          model_regs[SP_IDX] += 32'd4;
          stack_write(pc + 32'd5);
          pc = it.imm;
        end
        OP_CALL_R: begin
          model_regs[SP_IDX] += 32'd4;
          stack_write(pc + 32'd2);
          pc = model_regs[it.ra];
        end
        OP_RET: begin
          pc = stack_top();
          model_regs[SP_IDX] -= 32'd4;
        end
        OP_RETN: begin
          pc = stack_top();
          model_regs[SP_IDX] -= 32'd4 + {22'd0, it.drop, 2'b00};
        end
        default: pc = pc + 32'd1;
      endcase
      model_pc = pc;
    end
    view.pc   = model_pc;
    view.halt = model_halt;
    view.acc  = model_regs[0];
    view.cnt  = model_regs[1];
    return view;
  endfunction

  // ------------------------------------------------------------- stimulus

  task automatic send_instr(input instr_t it);
    // never pop from a slot that holds nothing yet
    if (!model_halt && (it.op == OP_POP || it.op == OP_RET || it.op == OP_RETN) &&
        !model_written[stack_slot(model_regs[SP_IDX])])
      it.op = OP_PUSH_I;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    operation       <= it.op;
    first_register  <= it.ra;
    second_register <= it.rb;
    immediate       <= it.imm;
    drop_count      <= it.drop;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_states.push_back(run_instruction(it));
    items_sent++;
  endtask

  task automatic send_fields(input logic [7:0] op, input int ra, input int rb,
                             input word_t imm, input logic [7:0] drop);
    instr_t it;
    it.op   = op;
    it.ra   = reg_idx_t'(ra);
    it.rb   = reg_idx_t'(rb);
    it.imm  = imm;
    it.drop = drop;
    send_instr(it);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_states.size() != 0) @(posedge clk);
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return word_t'($urandom_range(0, 64));
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic instr_t random_fields();
    instr_t it;
    it.op   = 8'($urandom_range(1, 255));
    it.ra   = reg_idx_t'($urandom_range(0, 7));
    it.rb   = reg_idx_t'($urandom_range(0, 7));
    it.imm  = rand_word();
    it.drop = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic instr_t random_alu(bit allow_sp);
    instr_t it;
    it = random_fields();
    case ($urandom_range(0, 11))
      0:  it.op = OP_MOV_I;
      1:  it.op = OP_MOV_R;
      2:  it.op = OP_ADD_I;
      3:  it.op = OP_ADD_R;
      4:  it.op = OP_SUB_I;
      5:  it.op = OP_SUB_R;
      6:  it.op = OP_AND_I;
      7:  it.op = OP_AND_R;
      8:  it.op = OP_OR_I;
      9:  it.op = OP_OR_R;
      10: it.op = OP_XOR_I;
      default: it.op = OP_XOR_R;
    endcase
    if ($urandom_range(0, 1)) it.ra = reg_idx_t'($urandom_range(0, 1));
    if (!allow_sp && it.ra == SP_IDX) it.ra = ~SP_IDX;
    return it;
  endfunction

  task automatic send_push_pop();
    instr_t it;
    it = random_fields();
    it.op = $urandom_range(0, 1) ? OP_PUSH_I : OP_PUSH_R;
    send_instr(it);
    repeat ($urandom_range(0, 2)) send_instr(random_alu(1'b0));
    it = random_fields();
    it.op = OP_POP;
    if ($urandom_range(0, 15) != 0 && it.ra == SP_IDX) it.ra = ~SP_IDX;
    send_instr(it);
  endtask

  // arguments pushed, call, body, then ret or retn that drops the arguments
  task automatic send_frame();
    instr_t it;
    int     args;
    args = $urandom_range(0, 3);
    repeat (args) begin
      it = random_fields();
      it.op = $urandom_range(0, 1) ? OP_PUSH_I : OP_PUSH_R;
      send_instr(it);
    end
    it = random_fields();
    it.op = $urandom_range(0, 1) ? OP_CALL_I : OP_CALL_R;
    send_instr(it);
    repeat ($urandom_range(0, 4)) send_instr(random_alu(1'b0));
    if ($urandom_range(0, 2) == 0) send_push_pop();
    it = random_fields();
    if (args == 0 && $urandom_range(0, 1)) begin
      it.op = OP_RET;
    end else begin
      it.op   = OP_RETN;
      it.drop = 8'(args);
    end
    send_instr(it);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_alu_ops();
    send_fields(OP_MOV_I, 0, 7, 32'hFFFF_FFFF, 8'hFF);
    send_fields(OP_ADD_I, 0, 7, 32'h0000_0001, 8'h00);
    send_fields(OP_SUB_I, 1, 0, 32'h0000_0001, 8'hFF);
    send_fields(OP_MOV_I, 2, 0, 32'h8000_0001, 8'h00);
    send_fields(OP_ADD_R, 0, 2, 32'hFFFF_FFFF, 8'h00);
    send_fields(OP_SUB_R, 1, 2, 32'h0000_0000, 8'h00);
    send_fields(OP_AND_I, 1, 7, 32'h0F0F_0F0F, 8'h00);
    send_fields(OP_AND_R, 0, 1, 32'h0000_0000, 8'h00);
    send_fields(OP_OR_I,  0, 7, 32'hF000_0000, 8'h00);
    send_fields(OP_OR_R,  1, 0, 32'h0000_0000, 8'h00);
    send_fields(OP_XOR_I, 1, 7, 32'hFFFF_FFFF, 8'h00);
    send_fields(OP_XOR_R, 0, 0, 32'h0000_0000, 8'h00);
    send_fields(OP_MOV_R, 1, 2, 32'h0000_0000, 8'h00);
  endtask

  task automatic test_stack_and_flow();
    send_fields(OP_PUSH_I, 0, 0, 32'hFFFF_FFFF, 8'h00);
    send_fields(OP_PUSH_R, 4, 0, 32'h0000_0000, 8'h00);
    send_fields(OP_POP,    4, 0, 32'h0000_0000, 8'h00);
    send_fields(OP_CALL_I, 0, 0, 32'h0000_0100, 8'h00);
    send_fields(OP_CALL_R, 4, 0, 32'h0000_0000, 8'h00);
    send_fields(OP_RET,    0, 0, 32'h0000_0000, 8'h00);
    send_fields(OP_RETN,   0, 0, 32'h0000_0000, 8'h00);
    send_fields(OP_RETN,   0, 0, 32'h0000_0000, 8'hFF);
    send_fields(OP_JMP_I,  0, 0, 32'hFFFF_FFFF, 8'h00);
    send_fields(OP_JMP_R,  1, 0, 32'h0000_0000, 8'h00);
    send_fields(8'(int'(OP_XOR_R) + 1), 7, 7, 32'h0000_0000, 8'h00);
    send_fields(8'hFF, 0, 0, 32'hFFFF_FFFF, 8'hFF);
    send_fields(OP_MOV_I,  4, 0, 32'h0000_0000, 8'h00);
  endtask

  task automatic test_random_programs(input int unsigned count, input bit vary_idle);
    int unsigned stop_at;
    instr_t      it;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if (vary_idle && $urandom_range(0, 99) == 0) idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0, 1: send_instr(random_alu($urandom_range(0, 9) == 0));
        2, 3: send_frame();
        4:    send_push_pop();
        5:    send_instr(random_fields());
        6: begin
          it = random_fields();
          it.op = $urandom_range(0, 1) ? OP_JMP_I : OP_JMP_R;
          send_instr(it);
        end
        default: begin
          // move the stack pointer somewhere else
          it = random_fields();
          it.op = $urandom_range(0, 1) ? OP_MOV_I : OP_ADD_I;
          it.ra = SP_IDX;
          send_instr(it);
        end
      endcase
    end
  endtask

  task automatic test_output_backpressure();
    hold_req = 1'b1;
    repeat (40) send_instr(random_alu(1'b0));
  endtask

  task automatic test_drain_pause();
    repeat (20) send_instr(random_fields());
    wait_for_results();
    repeat (20) send_instr(random_alu(1'b0));
  endtask

  task automatic test_back_to_back(input int unsigned count);
    idle_on = 1'b0;
    test_random_programs(count, 1'b0);
  endtask

  task automatic test_halt();
    idle_on = 1'b0;
    send_fields(OP_HALT, 0, 0, 32'h0000_0000, 8'h00);
    repeat (6) send_instr(random_fields());
  endtask

  // -------------------------------------------------------------- checking

  task automatic report_mismatch(input string field, input word_t got, input word_t want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch in result %0d, %0s: got %h, want %h", results_seen, field, got, want);
  endtask

  always @(posedge clk) begin
    cpu_view_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_states.size() == 0) begin
        report_mismatch("result with no transaction pending", next_pc, '0);
      end else begin
        want = pending_states.pop_front();
        if (next_pc !== want.pc) report_mismatch("next_pc", next_pc, want.pc);
        if (halted !== want.halt) report_mismatch("halted", word_t'(halted), word_t'(want.halt));
        if (accumulator_value !== want.acc)
          report_mismatch("accumulator_value", accumulator_value, want.acc);
        if (counter_value !== want.cnt) report_mismatch("counter_value", counter_value, want.cnt);
      end
      results_seen++;
    end
  end

  initial begin : rx_side
    int unsigned quiet;
    quiet = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (quiet != 0) begin
        quiet--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        quiet = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst             <= 1'b1;
    in_valid        <= 1'b0;
    operation       <= '0;
    first_register  <= '0;
    second_register <= '0;
    immediate       <= '0;
    drop_count      <= '0;
    model_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_alu_ops();
    test_stack_and_flow();
    test_random_programs(1000, 1'b1);
    test_output_backpressure();
    test_drain_pause();
    test_back_to_back(200);
    test_halt();

    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_states.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- bytecode_register_stack_cpu_step.f -----
rtl/core/bcsc_pkg.sv
rtl/core/bcsc_ram.sv
rtl/core/bcsc_exec.sv
rtl/core/bytecode_register_stack_cpu_step.sv
rtl/core/bcsc_checker.sv
tb/sv/testbench.sv
